// ----- hw/rtl/cv3_pkg.sv -----
// Shared types, constants and helpers for the 3x3 grayscale convolution block.
package cv3_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 8;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 48;
  localparam int IW_W      = 12;
  localparam int IH_W      = 13;
  localparam int ROW_W     = 13;
  localparam int PROD_W    = 25;
  localparam int SUM_W     = 29;
  localparam int CFG_IDX_W = 3;
  localparam int TAPS      = 9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEF_TOP    = 3'd0;
  localparam cfg_idx_t REG_COEF_MID    = 3'd1;
  localparam cfg_idx_t REG_COEF_BOTTOM = 3'd2;
  localparam cfg_idx_t REG_WIDTH       = 3'd3;
  localparam cfg_idx_t REG_HEIGHT      = 3'd4;

  localparam logic [CFG_W-1:0] COEF_TOP_RST    = 48'h0;
  localparam logic [CFG_W-1:0] COEF_MID_RST    = 48'h0000_0100_0000;
  localparam logic [CFG_W-1:0] COEF_BOTTOM_RST = 48'h0;
  localparam logic [IW_W-1:0]  WIDTH_RST       = 12'd640;
  localparam logic [IH_W-1:0]  HEIGHT_RST      = 13'd480;

  typedef struct packed {
    logic border;
    logic last;
  } res_ctl_t;

  typedef struct packed {
    logic     load;
    logic     zero_pix;
    logic     emit;
    res_ctl_t res;
  } pos_t;

  // tap r*3+c, r = 0 top row, c = 0 left column
  typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_W-1:0] row,
                                                       input int k);
    coef_at = $signed(row[COEF_W*k +: COEF_W]);
  endfunction

endpackage

// ----- hw/rtl/conv3x3_gray_border_copy.sv -----
// Top level: streaming 3x3 grayscale convolution with border copy.
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_stall  pixel_in, flush
//   res      out        res_valid / res_stall  pixel_out, last
//   cfg      in         cfg_write              cfg_index, cfg_data
//
// One request per clock while pix_stall is low. A result reaches the output register
// through three registered stages: line-store read, kernel products, then sum into
// the output register.
// Reset clears counters, window and stage valids; line stores are not cleared.
// A stalled result holds; requests are still taken until all three stages fill.
module conv3x3_gray_border_copy #(
  parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  cv3_pkg::cfg_idx_t              cfg_index,
  input  logic [cv3_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  logic [cv3_pkg::PIX_W-1:0]      pixel_in,
  input  logic                           flush,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [cv3_pkg::PIX_W-1:0]      pixel_out,
  output logic                           last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int PIX_W = cv3_pkg::PIX_W;
  localparam int IH_W  = cv3_pkg::IH_W;

  logic [cv3_pkg::CFG_W-1:0] coef_row_top, coef_row_mid, coef_row_bottom;
  logic [cv3_pkg::IW_W-1:0]  image_width;
  logic [IH_W-1:0]           image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row_top    <= cv3_pkg::COEF_TOP_RST;
      coef_row_mid    <= cv3_pkg::COEF_MID_RST;
      coef_row_bottom <= cv3_pkg::COEF_BOTTOM_RST;
      image_width     <= cv3_pkg::WIDTH_RST;
      image_height    <= cv3_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cv3_pkg::REG_COEF_TOP:    coef_row_top    <= cfg_data;
        cv3_pkg::REG_COEF_MID:    coef_row_mid    <= cfg_data;
        cv3_pkg::REG_COEF_BOTTOM: coef_row_bottom <= cfg_data;
        cv3_pkg::REG_WIDTH:       image_width     <= cfg_data[cv3_pkg::IW_W-1:0];
        cv3_pkg::REG_HEIGHT:      image_height    <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [CNT_W-1:0] w;
  logic [IH_W-1:0]  h;

  always_comb begin
    if (image_width == '0) begin
      w = CNT_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = CNT_W'(MAX_WIDTH);
    end else begin
      w = CNT_W'(image_width);
    end
    if (image_height == '0) begin
      h = IH_W'(1);
    end else if (32'(image_height) > cv3_pkg::MAX_HEIGHT) begin
      h = IH_W'(cv3_pkg::MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  cv3_pkg::pos_t    ctl;
  logic [COL_W-1:0] ic, oc;
  logic             fire;

  assign fire = pix_valid && !pix_stall;

  cv3_seq #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .flush(flush),
    .w    (w),
    .h    (h),
    .ctl  (ctl),
    .ic   (ic),
    .oc   (oc)
  );

  // stage A: line-store read
  logic              a_valid, a_emit, a_consume, f_ready;
  logic [PIX_W-1:0]  a_p;
  logic [COL_W-1:0]  a_ic, a_oc;
  cv3_pkg::res_ctl_t a_res;

  // write that landed on the edge this request was read
  logic              fwd_valid;
  logic [COL_W-1:0]  fwd_addr;
  logic [PIX_W-1:0]  fwd_older, fwd_newer;

  logic [PIX_W-1:0]  old_rd_a, old_rd_b, new_rd;
  logic [PIX_W-1:0]  a_val, b_val, c_val;
  logic              hit_ic, hit_oc;

  assign a_consume = a_valid && (!a_emit || f_ready);
  assign pix_stall = a_valid && !a_consume;

  assign hit_ic = fwd_valid && (fwd_addr == a_ic);
  assign hit_oc = fwd_valid && (fwd_addr == a_oc);
  assign a_val  = hit_ic ? fwd_older : old_rd_a;
  assign b_val  = hit_ic ? fwd_newer : new_rd;
  assign c_val  = hit_oc ? fwd_older : old_rd_b;

  cv3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_older (
    .clk      (clk),
    .wr_en    (a_consume),
    .wr_addr  (a_ic),
    .wr_data  (b_val),
    .rd_en    (ctl.load),
    .rd_addr_a(ic),
    .rd_data_a(old_rd_a),
    .rd_addr_b(oc),
    .rd_data_b(old_rd_b)
  );

  cv3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_newer (
    .clk      (clk),
    .wr_en    (a_consume),
    .wr_addr  (a_ic),
    .wr_data  (a_p),
    .rd_en    (ctl.load),
    .rd_addr_a(ic),
    .rd_data_a(new_rd),
    .rd_addr_b(ic),
    .rd_data_b()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        a_valid   <= 1'b1;
        fwd_valid <= a_consume;
      end else if (a_consume) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_p       <= ctl.zero_pix ? '0 : pixel_in;
      a_ic      <= ic;
      a_oc      <= oc;
      a_emit    <= ctl.emit;
      a_res     <= ctl.res;
      fwd_addr  <= a_ic;
      fwd_older <= b_val;
      fwd_newer <= a_p;
    end
  end

  // 3x3 window
  cv3_pkg::taps_t win, win_next;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]   = win[r*3+1];
      win_next[r*3+1] = win[r*3+2];
    end
    win_next[2] = a_val;
    win_next[5] = b_val;
    win_next[8] = a_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (a_consume) begin
      win <= win_next;
    end
  end

  cv3_filter u_filter (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (a_valid && a_emit),
    .req_ready      (f_ready),
    .taps           (win_next),
    .center         (c_val),
    .res            (a_res),
    .coef_row_top   (coef_row_top),
    .coef_row_mid   (coef_row_mid),
    .coef_row_bottom(coef_row_bottom),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .pixel_out      (pixel_out),
    .last           (last)
  );

endmodule

// ----- hw/rtl/cv3_ram.sv -----
// Generic RAM: one write port, two registered read ports, read-first.
module cv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- hw/rtl/cv3_seq.sv -----
// Raster position counters, drain tracking and per-request flags.
module cv3_seq #(
  parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  input  logic                             flush,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w,
  input  logic [cv3_pkg::IH_W-1:0]         h,
  output cv3_pkg::pos_t                    ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]     ic,
  output logic [$clog2(MAX_WIDTH)-1:0]     oc
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = cv3_pkg::ROW_W;

  logic [COL_W-1:0] in_column, in_column_next;
  logic [COL_W-1:0] out_column, out_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [ROW_W-1:0] out_row, out_row_next;
  logic             draining, draining_next;

  logic [CNT_W-1:0] in_col_inc, out_col_inc;
  logic [ROW_W-1:0] h_last;
  logic             emit, row_end, col_end;

  always_comb begin
    h_last      = h - ROW_W'(1);
    emit        = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
    row_end     = out_row >= h_last;
    col_end     = CNT_W'(out_column) >= (w - CNT_W'(1));

    ctl.load       = fire && (draining || !flush);
    ctl.zero_pix   = draining;
    ctl.emit       = emit;
    ctl.res.border = (out_row == '0) || row_end || (out_column == '0) || col_end;
    ctl.res.last   = row_end && col_end;

    in_col_inc = CNT_W'(in_column) + CNT_W'(1);
    if (in_col_inc >= w) begin
      in_column_next = '0;
      in_row_next    = (in_row != '1) ? in_row + ROW_W'(1) : in_row;
    end else begin
      in_column_next = COL_W'(in_col_inc);
      in_row_next    = in_row;
    end
    draining_next   = draining || (in_row_next >= h);
    out_column_next = out_column;
    out_row_next    = out_row;
    out_col_inc     = CNT_W'(out_column) + CNT_W'(1);

    if (emit) begin
      if (ctl.res.last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
        draining_next   = 1'b0;
      end else if (out_col_inc >= w) begin
        out_column_next = '0;
        out_row_next    = out_row + ROW_W'(1);
      end else begin
        out_column_next = COL_W'(out_col_inc);
      end
    end
  end

  assign ic = in_column;
  assign oc = out_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      draining   <= 1'b0;
    end else if (ctl.load) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      draining   <= draining_next;
    end
  end

endmodule

// ----- hw/rtl/cv3_filter.sv -----
// Kernel products, sum, shift and clamp, border select and result register.
module cv3_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  cv3_pkg::taps_t              taps,
  input  logic [cv3_pkg::PIX_W-1:0]   center,
  input  cv3_pkg::res_ctl_t           res,
  input  logic [cv3_pkg::CFG_W-1:0]   coef_row_top,
  input  logic [cv3_pkg::CFG_W-1:0]   coef_row_mid,
  input  logic [cv3_pkg::CFG_W-1:0]   coef_row_bottom,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [cv3_pkg::PIX_W-1:0]   pixel_out,
  output logic                        last
);

  localparam int PROD_W = cv3_pkg::PROD_W;
  localparam int SUM_W  = cv3_pkg::SUM_W;
  localparam int PIX_W  = cv3_pkg::PIX_W;

  logic signed [PROD_W-1:0] prod [cv3_pkg::TAPS];
  logic signed [PROD_W-1:0] prod_next [cv3_pkg::TAPS];
  logic [PIX_W-1:0]         b_center;
  cv3_pkg::res_ctl_t        b_res;
  logic                     b_valid;

  logic signed [SUM_W-1:0]  row_sum [3];
  logic signed [SUM_W-1:0]  sum, shifted;
  logic [PIX_W-1:0]         filt;
  logic                     o_ready;
  logic [cv3_pkg::CFG_W-1:0] rows [3];

  assign rows[0] = coef_row_top;
  assign rows[1] = coef_row_mid;
  assign rows[2] = coef_row_bottom;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[r*3+c] = PROD_W'($signed({1'b0, taps[r*3+c]})) *
                           PROD_W'(cv3_pkg::coef_at(rows[r], c));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SUM_W'(prod[r*3]) + SUM_W'(prod[r*3+1]) + SUM_W'(prod[r*3+2]);
    end
    sum     = row_sum[0] + row_sum[1] + row_sum[2];
    shifted = sum >>> cv3_pkg::COEF_FRAC_BITS;
    if (sum[SUM_W-1]) begin
      filt = '0;
    end else if (shifted > SUM_W'(255)) begin
      filt = '1;
    end else begin
      filt = shifted[PIX_W-1:0];
    end
  end

  assign o_ready   = !res_valid || !res_stall;
  assign req_ready = !b_valid || o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        b_valid <= req_valid;
      end
      if (o_ready) begin
        res_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      prod     <= prod_next;
      b_center <= center;
      b_res    <= res;
    end
    if (o_ready && b_valid) begin
      pixel_out <= b_res.border ? b_center : filt;
      last      <= b_res.last;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench for conv3x3_gray_border_copy: frame-level checks against a behavioural predictor.
module testbench;

  localparam int PIX_W          = cv3_pkg::PIX_W;
  localparam int CFG_W          = cv3_pkg::CFG_W;
  localparam int IW_W           = cv3_pkg::IW_W;
  localparam int IH_W           = cv3_pkg::IH_W;
  localparam int COEF_W         = cv3_pkg::COEF_W;
  localparam int MAX_WIDTH      = cv3_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT     = cv3_pkg::MAX_HEIGHT;
  localparam int COEF_FRAC_BITS = cv3_pkg::COEF_FRAC_BITS;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             fin;
  } out_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  cv3_pkg::cfg_idx_t    cfg_index = cv3_pkg::REG_COEF_TOP;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 flush = 1'b0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic                 last;

  // predictor state
  logic [CFG_W-1:0]     kcoef [3];
  logic [IW_W-1:0]      cfg_width;
  logic [IH_W-1:0]      cfg_height;
  logic [PIX_W-1:0]     line_old [MAX_WIDTH];
  logic [PIX_W-1:0]     line_new [MAX_WIDTH];
  logic [PIX_W-1:0]     win [3][3];
  int                   in_col, in_row, out_col, out_row;
  bit                   draining;
  out_pixel_t           due [$];

  int                   mismatches = 0;
  int                   sent_requests;
  bit                   idle_on = 1'b0;
  int                   stall_left = 0;

  conv3x3_gray_border_copy dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pixel_in  (pixel_in),
    .flush     (flush),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .pixel_out (pixel_out),
    .last      (last)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(cfg_height);
  endfunction

  function automatic void clear_filter_state();
    kcoef[0] = cv3_pkg::COEF_TOP_RST;
    kcoef[1] = cv3_pkg::COEF_MID_RST;
    kcoef[2] = cv3_pkg::COEF_BOTTOM_RST;
    cfg_width = cv3_pkg::WIDTH_RST;
    cfg_height = cv3_pkg::HEIGHT_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    draining = 1'b0;
  endfunction

  // one accepted request: advance line stores and window, queue the pixel it releases
  function automatic void convolve_pixel(input logic [PIX_W-1:0] pix_i, input logic fl);
    int w, h, ic, oc, s;
    logic [PIX_W-1:0] p, a, b, ctr, res;
    bit emit, fin;
    w = eff_width();
    h = eff_height();
    if (!draining && fl) return;
    p = draining ? '0 : pix_i;
    oc = (out_col < MAX_WIDTH) ? out_col : MAX_WIDTH - 1;
    ctr = line_old[oc];
    ic = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
    a = line_old[ic];
    b = line_new[ic];
    line_old[ic] = b;
    line_new[ic] = p;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = a;
    win[1][2] = b;
    win[2][2] = p;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;
    end
    if (in_row >= h) draining = 1'b1;
    if (!emit) return;
    if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1) begin
      res = ctr;
    end else begin
      s = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          s += int'(win[r][c]) * int'($signed(kcoef[r][COEF_W*c +: COEF_W]));
      if (s < 0) begin
        res = '0;
      end else begin
        s = s >>> COEF_FRAC_BITS;
        res = (s > 255) ? 8'd255 : s[7:0];
      end
    end
    fin = (out_row >= h - 1) && (out_col >= w - 1);
    if (fin) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      draining = 1'b0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    due.push_back('{pix: res, fin: fin});
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int s;
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 16'hFFFF));
    s = int'($urandom_range(0, 160)) - 48;
    return s[15:0];
  endfunction

  function automatic logic [CFG_W-1:0] pack_row(input logic [COEF_W-1:0] l,
                                                input logic [COEF_W-1:0] m,
                                                input logic [COEF_W-1:0] r);
    return {r, m, l};
  endfunction

  task automatic write_reg(input cv3_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      cv3_pkg::REG_COEF_TOP:    kcoef[0] = val;
      cv3_pkg::REG_COEF_MID:    kcoef[1] = val;
      cv3_pkg::REG_COEF_BOTTOM: kcoef[2] = val;
      cv3_pkg::REG_WIDTH:       cfg_width = val[IW_W-1:0];
      cv3_pkg::REG_HEIGHT:      cfg_height = val[IH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input logic [PIX_W-1:0] pix, input logic fl);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pixel_in <= pix;
    flush <= fl;
    do begin
      @(negedge clk);
      taken = !pix_stall;
      @(posedge clk);
    end while (!taken);
    convolve_pixel(pix, fl);
  endtask

  // raster pixels with stray ignored flushes, then the drain requests
  task automatic send_frame(input int flush_odds);
    int w, h;
    w = eff_width();
    h = eff_height();
    for (int n = 0; n < w * h; n++) begin
      if (flush_odds != 0 && $urandom_range(1, flush_odds) == 1)
        send_item(pick_pixel(), 1'b1);
      send_item(pick_pixel(), 1'b0);
    end
    for (int n = 0; n <= w; n++)
      send_item(pick_pixel(), 1'($urandom_range(0, 1)));
    sent_requests += w * h + w + 1;
  endtask

  task automatic settle();
    pix_valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(cv3_pkg::REG_WIDTH, CFG_W'(w));
    write_reg(cv3_pkg::REG_HEIGHT, CFG_W'(h));
  endtask

  // zero width and zero height are taken as one
  task automatic test_size_clamps();
    idle_on = 1'b1;
    set_size(0, 3);
    send_frame(0);
    settle();
    set_size(5, 0);
    send_frame(0);
    settle();
    set_size(1, 1);
    send_frame(0);
    settle();
  endtask

  // reset kernel is identity; flushes inside the frame are dropped
  task automatic test_borders_and_flush();
    set_size(4, 4);
    send_frame(3);
    send_item(8'd255, 1'b1);
    settle();
  endtask

  task automatic test_kernel_extremes();
    set_size(3, 3);
    write_reg(cv3_pkg::REG_COEF_TOP, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(cv3_pkg::REG_COEF_MID, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    write_reg(cv3_pkg::REG_COEF_BOTTOM, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_frame(0);
    settle();
    write_reg(cv3_pkg::REG_COEF_TOP, pack_row(16'h8000, 16'h8000, 16'h8000));
    write_reg(cv3_pkg::REG_COEF_MID, pack_row(16'h8000, 16'h8000, 16'h8000));
    write_reg(cv3_pkg::REG_COEF_BOTTOM, pack_row(16'h8000, 16'h8000, 16'h8000));
    send_frame(0);
    settle();
  endtask

  task automatic run_frames(input int budget, input bit allow_idle);
    int w, h;
    sent_requests = 0;
    while (sent_requests < budget) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: w = $urandom_range(1, 2);
        1: w = $urandom_range(24, 64);
        default: w = $urandom_range(3, 12);
      endcase
      h = (w > 12) ? 3 : (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(3, 9));
      set_size(w, h);
      write_reg(cv3_pkg::REG_COEF_TOP, pack_row(pick_coef(), pick_coef(), pick_coef()));
      write_reg(cv3_pkg::REG_COEF_MID, pack_row(pick_coef(), pick_coef(), pick_coef()));
      write_reg(cv3_pkg::REG_COEF_BOTTOM, pack_row(pick_coef(), pick_coef(), pick_coef()));
      send_frame(12);
      if ($urandom_range(0, 3) == 0) send_item(pick_pixel(), 1'b1);
      settle();
    end
  endtask

  task automatic test_random_frames();
    run_frames(450, 1'b1);
  endtask

  task automatic test_full_rate();
    run_frames(150, 1'b0);
  endtask

  // output side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_pixel_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel %0d last %0b", pixel_out, last));
      end else begin
        want = due.pop_front();
        if (pixel_out !== want.pix)
          report_mismatch($sformatf("pixel_out %0d, want %0d", pixel_out, want.pix));
        if (last !== want.fin)
          report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
      end
    end
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    clear_filter_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_size_clamps();
    test_borders_and_flush();
    test_kernel_extremes();
    test_random_frames();
    test_full_rate();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
